// ----- design/mse_loss_forward_backward_unit_macros.svh -----
// Assertion macros used by the checker file of the loss unit.
`ifndef MSE_LOSS_FORWARD_BACKWARD_UNIT_MACROS_SVH
`define MSE_LOSS_FORWARD_BACKWARD_UNIT_MACROS_SVH

// Overlapping implication, checked on clk_i and switched off while rst_ni is low.
`define MLFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MLFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mlfb_pkg.sv -----
// Shared types and constants of the mean squared error loss unit.
package mlfb_pkg;

  // Field and datapath widths.
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned PROD_W  = 34;
  localparam int unsigned OUT_W   = 33;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // Item count limit for the forward accumulation.
  localparam logic [CNT_W-1:0] MAX_ELEMENTS = 17'd65536;

  // Divider step counts less one: full dividend and gradient dividend.
  localparam logic [STEP_W-1:0] LONG_STEPS  = 6'd47;
  localparam logic [STEP_W-1:0] SHORT_STEPS = 6'd31;

  // Queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned FCNT_W     = 3;

  // Operation codes and result kinds.
  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;
  localparam logic KIND_LOSS   = 1'b0;
  localparam logic KIND_GRAD   = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  // Classified item handed from front to back.
  typedef struct packed {
    logic                     op;
    logic                     last;
    logic signed [DIFF_W-1:0] diff;
    logic signed [VAL_W-1:0]  grad;
  } item_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic              short_op;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- design/mlfb_front.sv -----
// Front stage: takes input transactions and forms the difference of each item.
module mlfb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_op_i,
  input  logic                          in_last_i,
  input  logic [mlfb_pkg::VAL_W-1:0]    pred_i,
  input  logic [mlfb_pkg::VAL_W-1:0]    target_i,
  input  logic [mlfb_pkg::VAL_W-1:0]    grad_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output mlfb_pkg::item_t               item_o
);
  import mlfb_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  // The holding register frees up in the cycle the queue takes its item.
  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (item_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d     = 1'b1;
      item_d.op   = in_op_i;
      item_d.last = in_last_i;
      item_d.diff = $signed({pred_i[VAL_W-1], pred_i}) - $signed({target_i[VAL_W-1], target_i});
      item_d.grad = $signed(grad_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- design/mlfb_fifo.sv -----
// Short queue of classified items between the front and the back.
module mlfb_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  mlfb_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output mlfb_pkg::item_t pop_item_o
);
  import mlfb_pkg::*;

  item_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != FCNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- design/mlfb_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by loss and gradient.
module mlfb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlfb_pkg::div_req_t req_i,
  output mlfb_pkg::div_rsp_t rsp_o
);
  import mlfb_pkg::*;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  div_state_e        state_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_q, dvd_q[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    fits    = (rem_sh >= {1'b0, dsr_q});
  end

  // Quotient bits shift in at the bottom of the dividend register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        DIV_IDLE: begin
          done_q <= 1'b0;
          if (req_i.start) begin
            dvd_q   <= req_i.dividend;
            dsr_q   <= req_i.divisor;
            rem_q   <= '0;
            step_q  <= req_i.short_op ? SHORT_STEPS : LONG_STEPS;
            state_q <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          dvd_q <= {dvd_q[SUM_W-2:0], fits};
          rem_q <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          if (step_q == '0) begin
            done_q  <= 1'b1;
            state_q <= DIV_IDLE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        default: begin
          state_q <= DIV_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ----- design/mlfb_back.sv -----
// Back stage: squares or scales each item, keeps the running sum and drives results.
module mlfb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  mlfb_pkg::item_t               item_i,
  input  logic [mlfb_pkg::CNT_W-1:0]    element_count_i,
  output mlfb_pkg::div_req_t            div_req_o,
  input  mlfb_pkg::div_rsp_t            div_rsp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [mlfb_pkg::OUT_W-1:0]    out_value_o
);
  import mlfb_pkg::*;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_DIV,
    BK_OUT
  } back_state_e;

  back_state_e              state_q;
  item_t                    cur_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]         sum_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  div_req_t                 req_q;
  logic                     out_valid_q;
  logic                     out_kind_q;
  logic [OUT_W-1:0]         out_value_q;

  logic signed [DIFF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W-1:0]         sum_new;
  logic [CNT_W-1:0]         cnt_new;
  logic [PROD_W-1:0]        prod_abs;
  logic [SQ_W-1:0]          grad_mag;
  logic [CNT_W-1:0]         divisor_n;
  logic [SQ_W-1:0]          loss_val;
  logic [OUT_W-1:0]         grad_pos;

  // Forward squares the difference, backward multiplies it by the upstream gradient.
  always_comb begin
    mul_b = (cur_q.op == OP_BACKWARD) ? DIFF_W'(cur_q.grad) : cur_q.diff;
    mul_p = PROD_W'(cur_q.diff) * PROD_W'(mul_b);
  end

  // Saturating sum and count update for a forward item.
  always_comb begin
    sum_add = {1'b0, sum_q} + {{(SUM_W - SQ_W + 1){1'b0}}, prod_q[SQ_W-1:0]};
    sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    cnt_new = (cnt_q < MAX_ELEMENTS) ? cnt_q + 1'b1 : cnt_q;
  end

  // Gradient magnitude is twice the product; a zero element count divides by one.
  always_comb begin
    prod_abs  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    grad_mag  = {prod_abs[SQ_W-2:0], 1'b0};
    divisor_n = (element_count_i == '0) ? CNT_W'(1) : element_count_i;
  end

  // Result formatting: the loss saturates, the gradient takes its sign back.
  always_comb begin
    loss_val = (div_rsp_i.quotient[SUM_W-1:SQ_W] != '0) ? {SQ_W{1'b1}}
                                                        : div_rsp_i.quotient[SQ_W-1:0];
    grad_pos = {1'b0, div_rsp_i.quotient[SQ_W-1:0]};
  end

  assign item_ready_o = (state_q == BK_IDLE);

  // Sequencer with its registered outputs and the accumulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_LOSS;
      out_value_q <= '0;
      cur_q       <= '0;
      prod_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      unique case (state_q)
        BK_IDLE: begin
          if (item_valid_i) begin
            cur_q   <= item_i;
            state_q <= BK_MUL;
          end
        end
        BK_MUL: begin
          prod_q  <= mul_p;
          state_q <= BK_ACC;
        end
        BK_ACC: begin
          if (cur_q.op == OP_FORWARD) begin
            if (cur_q.last) begin
              req_q.start    <= 1'b1;
              req_q.short_op <= 1'b0;
              req_q.dividend <= sum_new;
              req_q.divisor  <= cnt_new;
              sum_q          <= '0;
              cnt_q          <= '0;
              state_q        <= BK_DIV;
            end else begin
              sum_q   <= sum_new;
              cnt_q   <= cnt_new;
              state_q <= BK_IDLE;
            end
          end else begin
            req_q.start    <= 1'b1;
            req_q.short_op <= 1'b1;
            req_q.dividend <= {grad_mag, {(SUM_W - SQ_W){1'b0}}};
            req_q.divisor  <= divisor_n;
            neg_q          <= prod_q[PROD_W-1];
            state_q        <= BK_DIV;
          end
        end
        BK_DIV: begin
          req_q.start <= 1'b0;
          if (div_rsp_i.done) begin
            out_valid_q <= 1'b1;
            if (cur_q.op == OP_FORWARD) begin
              out_kind_q  <= KIND_LOSS;
              out_value_q <= {1'b0, loss_val};
            end else begin
              out_kind_q  <= KIND_GRAD;
              out_value_q <= neg_q ? OUT_W'(-grad_pos) : grad_pos;
            end
            state_q <= BK_OUT;
          end
        end
        BK_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= BK_IDLE;
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
    end
  end

  assign div_req_o   = req_q;
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;

endmodule

// ----- design/mse_loss_forward_backward_unit.sv -----
// Top level of the mean squared error loss unit with forward and gradient modes.
//
//  Channel   Dir   Payload                                        Handshake
//  s_axis    in    tdata pred/target/grad, tuser opcode, tlast    tvalid/tready
//  m_axis    out   tdata result_value, tuser result_kind          tvalid/tready
//  APB       in    element_count at byte address 0                psel/penable, pready high
//
//  A forward item that is not last holds the back stage through BK_MUL and BK_ACC.
//  A gradient item or a last forward item also holds it in BK_DIV until the
//  one-bit-per-cycle divider (32 or 48 steps) is done, then in BK_OUT until the
//  result is taken on m_axis.
//  Reset is asynchronous and active low; it clears the running sum and count and
//  sets element_count to 1. The front and a four-entry queue keep taking transactions
//  while the back stage works or its result waits on m_axis_tready, until they fill.
module mse_loss_forward_backward_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] pred_value, [31:16] target_value, [47:32] upstream_grad
  input  logic [mlfb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // [0] opcode
  input  logic                                  s_axis_tuser,
  input  logic                                  s_axis_tlast,
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [32:0] result_value, [39:33] zero
  output logic [mlfb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // [0] result_kind
  output logic                                  m_axis_tuser,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mlfb_pkg::ADDR_W-1:0]           paddr,
  input  logic [mlfb_pkg::DATA_W-1:0]           pwdata,
  output logic [mlfb_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import mlfb_pkg::*;

  logic [CNT_W-1:0] ecount_q;
  logic             front_valid, front_ready;
  item_t            front_item;
  logic             queue_valid, queue_ready;
  item_t            queue_item;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [OUT_W-1:0] out_value;

  // Configuration register write and read back.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q <= CNT_W'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ELEMENT_COUNT)) begin
      ecount_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? {{(DATA_W - CNT_W){1'b0}}, ecount_q} : '0;

  // Front end.
  mlfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .pred_i       (s_axis_tdata[15:0]),
    .target_i     (s_axis_tdata[31:16]),
    .grad_i       (s_axis_tdata[47:32]),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  // Queue between front and back.
  mlfb_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  // Back end and its divider.
  mlfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (queue_valid),
    .item_ready_o    (queue_ready),
    .item_i          (queue_item),
    .element_count_i (ecount_q),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_kind_o      (m_axis_tuser),
    .out_value_o     (out_value)
  );

  mlfb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_value};

endmodule

// ----- design/mlfb_checker.sv -----
// Port-level checks of the loss unit and their binding to the top level.
`include "mse_loss_forward_backward_unit_macros.svh"

module mlfb_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic [mlfb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input logic                                  s_axis_tuser,
  input logic                                  s_axis_tlast,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [mlfb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input logic                                  m_axis_tuser,
  input logic                                  psel,
  input logic                                  penable,
  input logic                                  pwrite,
  input logic [mlfb_pkg::ADDR_W-1:0]           paddr,
  input logic [mlfb_pkg::DATA_W-1:0]           pwdata,
  input logic [mlfb_pkg::DATA_W-1:0]           prdata,
  input logic                                  pready
);
  import mlfb_pkg::*;

  // A loss result is saturated below two to the thirty-two, so it is never negative.
  `MLFB_ASSERT_IMP(a_loss_nonneg, m_axis_tvalid && (m_axis_tuser == KIND_LOSS), m_axis_tdata[OUT_W-1] == 1'b0, "loss result has its sign bit set")

  // The padding above the result value stays zero.
  `MLFB_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0, "result padding bits not zero")

  // A stalled result transaction keeps its value and kind.
  `MLFB_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // A written element count reads back in the next cycle.
  `MLFB_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite && pready && (paddr[2] == REG_ELEMENT_COUNT), (paddr[2] != REG_ELEMENT_COUNT) || (prdata[CNT_W-1:0] == $past(pwdata[CNT_W-1:0])), "element count read back differs from the write")

endmodule

bind mse_loss_forward_backward_unit mlfb_checker u_mlfb_checker (.*);

// ----- bench/tb_mse_loss_forward_backward_unit.sv -----
// Self-checking testbench for the mean squared error loss unit, forward and gradient modes.
`timescale 1ns / 1ps

module tb_mse_loss_forward_backward_unit;
  import mlfb_pkg::*;

  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 225;
  localparam int unsigned LONG_RUN_ITEMS  = 64;

  localparam logic [ADDR_W-1:0] ELEMENT_COUNT_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] UNUSED_REG_ADDR    = 3'd4;

  localparam longint unsigned SQ_SUM_CEIL = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned LOSS_CEIL   = (64'd1 << 32) - 64'd1;

  localparam logic [VAL_W-1:0] Q88_MAX = 16'h7FFF;
  localparam logic [VAL_W-1:0] Q88_MIN = 16'h8000;
  localparam logic [VAL_W-1:0] Q88_ONE = 16'h0100;

  typedef struct packed {
    logic             kind;
    logic [OUT_W-1:0] value;
  } mse_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_RARELY} rx_style_e;

  // Clock, reset and block ports.
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [ADDR_W-1:0]      paddr         = '0;
  logic [DATA_W-1:0]      pwdata        = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  // Mirror of the block's state and register, and results still owed by it.
  logic [SUM_W-1:0] running_sq_sum    = '0;
  logic [CNT_W-1:0] running_count     = '0;
  logic [CNT_W-1:0] cfg_element_count = 17'd1;
  mse_result_t      pending_results[$];

  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned style_left    = 0;
  rx_style_e   rx_style      = RX_ALWAYS;
  bit          sender_bursty = 1'b1;
  int unsigned burst_left    = 0;

  mse_loss_forward_backward_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Works out the result of one item and advances the mirrored state.
  function automatic bit compute_mse_result(input logic op,
                                            input logic signed [VAL_W-1:0] pred,
                                            input logic signed [VAL_W-1:0] targ,
                                            input logic signed [VAL_W-1:0] grad,
                                            input logic last,
                                            output mse_result_t res);
    longint          diff;
    longint          prod;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned quot;
    longint unsigned divisor;
    res  = '0;
    diff = longint'(pred) - longint'(targ);
    if (op == OP_FORWARD) begin
      mag = (diff < 0) ? -diff : diff;
      sq  = mag * mag;
      if (running_sq_sum > SQ_SUM_CEIL - sq) begin
        running_sq_sum = '1;
      end else begin
        running_sq_sum = running_sq_sum + sq[SUM_W-1:0];
      end
      if (running_count < MAX_ELEMENTS) begin
        running_count = running_count + 1'b1;
      end
      if (!last) begin
        return 1'b0;
      end
      divisor = (running_count == '0) ? 64'd1 : running_count;
      quot    = running_sq_sum / divisor;
      if (quot > LOSS_CEIL) begin
        quot = LOSS_CEIL;
      end
      res.kind       = KIND_LOSS;
      res.value      = quot[OUT_W-1:0];
      running_sq_sum = '0;
      running_count  = '0;
      return 1'b1;
    end
    // The gradient leaves the running sum alone and ignores the last flag.
    prod    = longint'(grad) * diff * 2;
    mag     = (prod < 0) ? -prod : prod;
    divisor = (cfg_element_count == '0) ? 64'd1 : cfg_element_count;
    quot    = mag / divisor;
    if (prod < 0) begin
      quot = 64'd0 - quot;
    end
    res.kind  = KIND_GRAD;
    res.value = quot[OUT_W-1:0];
    return 1'b1;
  endfunction

  // Predict on every accepted input transaction.
  always @(posedge clk_i) begin : predict_inputs
    mse_result_t res;
    bit          produced;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      produced = compute_mse_result(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                                    s_axis_tdata[47:32], s_axis_tlast, res);
      if (produced) begin
        pending_results.push_back(res);
      end
    end
  end

  // Compare every accepted result transaction with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    mse_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_kind %0d result_value 0x%0h",
               m_axis_tuser, m_axis_tdata[OUT_W-1:0]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[OUT_W-1:0] !== want.value) begin
          $error("result_value: expected 0x%0h, got 0x%0h",
                 want.value, m_axis_tdata[OUT_W-1:0]);
          fail_count++;
        end
      end
    end
  end

  // Receiver: stall styles that change now and then, plus an occasional long hold-off.
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (style_left == 0) begin
      rx_style   = rx_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(32, 256);
    end else begin
      style_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
        RX_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("mse_loss_forward_backward_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gaps: bursts of random length separated by random gaps.
  task automatic pause_sender();
    int unsigned gap;
    if (!sender_bursty) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    gap        = $urandom_range(1, 12);
    s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic send_item(input logic op, input logic [VAL_W-1:0] pred,
                           input logic [VAL_W-1:0] targ, input logic [VAL_W-1:0] grad,
                           input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    s_axis_tdata  <= {grad, targ, pred};
    do @(posedge clk_i); while (!s_axis_tready);
    pause_sender();
  endtask

  // Stop sending, wait for every owed result, then let trailing work finish.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[ADDR_W-1:2] == 1'b0 && addr[2] == REG_ELEMENT_COUNT) begin
      cfg_element_count = data[CNT_W-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_element_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ELEMENT_COUNT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(DATA_W-CNT_W){1'b0}}, cfg_element_count}) begin
      $error("element_count: expected 0x%0h, got 0x%0h", cfg_element_count, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_element_count(input logic [DATA_W-1:0] data);
    drain_block();
    apb_write(ELEMENT_COUNT_ADDR, data);
    check_element_reg();
  endtask

  // Random Q8.8 value, with the extremes now and then.
  function automatic logic [VAL_W-1:0] rand_q88();
    case ($urandom_range(0, 15))
      0:       return Q88_MAX;
      1:       return Q88_MIN;
      2:       return '0;
      3:       return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Register writes: masking of wide data, the zero count, and an unused index.
  task automatic test_register_access();
    set_element_count(32'hFFFF_FFFF);
    send_item(OP_BACKWARD, Q88_MIN, Q88_MAX, Q88_MIN, 1'b0);
    send_item(OP_BACKWARD, Q88_MAX, Q88_MIN, Q88_MAX, 1'b1);
    drain_block();
    apb_write(UNUSED_REG_ADDR, 32'd5);
    check_element_reg();
    send_item(OP_BACKWARD, Q88_MAX, Q88_MIN, Q88_MIN, 1'b0);
    set_element_count(32'd0);
    send_item(OP_BACKWARD, Q88_MIN, Q88_MAX, Q88_MIN, 1'b0);
    send_item(OP_BACKWARD, Q88_MIN, Q88_MAX, Q88_MAX, 1'b0);
    set_element_count(32'hAAAA_0003);
    // Negative quotients are truncated toward zero.
    send_item(OP_BACKWARD, 16'h0000, 16'h0001, 16'h0001, 1'b0);
    send_item(OP_BACKWARD, 16'h0000, 16'h0002, 16'h0001, 1'b0);
    set_element_count(32'd65536);
    send_item(OP_BACKWARD, Q88_MAX, Q88_MIN, Q88_ONE, 1'b0);
  endtask

  // Forward runs: extremes, truncation and a gradient inside a run.
  task automatic test_forward_loss();
    send_item(OP_FORWARD, Q88_MAX, Q88_MIN, '0, 1'b1);
    send_item(OP_FORWARD, Q88_MIN, Q88_MAX, '0, 1'b1);
    send_item(OP_FORWARD, 16'h1234, 16'h1234, '0, 1'b1);
    send_item(OP_FORWARD, 16'h0001, 16'h0000, '0, 1'b0);
    send_item(OP_FORWARD, 16'h0000, 16'h0002, '0, 1'b0);
    send_item(OP_FORWARD, 16'hFFFE, 16'h0000, '0, 1'b1);
    send_item(OP_FORWARD, 16'h0001, 16'h0000, '0, 1'b0);
    send_item(OP_FORWARD, 16'h0002, 16'h0000, '0, 1'b1);
    // The last flag on a gradient item must not close the forward run.
    send_item(OP_FORWARD, 16'h0003, 16'h0000, '0, 1'b0);
    send_item(OP_BACKWARD, 16'h0003, 16'h0000, Q88_ONE, 1'b1);
    send_item(OP_FORWARD, 16'h0000, 16'h0001, '0, 1'b1);
  endtask

  // The receiver holds off while gradients keep coming, so the input must stall.
  task automatic test_output_backpressure();
    drain_block();
    sender_bursty = 1'b0;
    hold_requests++;
    repeat (24) send_item(OP_BACKWARD, rand_q88(), rand_q88(), rand_q88(), 1'b0);
    sender_bursty = 1'b1;
  endtask

  // Mostly well-formed forward runs mixed with gradients, under several counts.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    logic [DATA_W-1:0] count_word;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       count_word = 32'd1;
        1:       count_word = 32'd0;
        2:       count_word = 32'd131071;
        3:       count_word = 32'd65536;
        4:       count_word = ($urandom & 32'hFFFE_0000) | $urandom_range(2, 64);
        default: count_word = $urandom;
      endcase
      set_element_count(count_word);
      sender_bursty = (phase != 2);
      sent          = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          run_len = $urandom_range(1, 24);
          for (int unsigned i = 0; i < run_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_item(OP_BACKWARD, rand_q88(), rand_q88(), rand_q88(),
                        1'($urandom_range(0, 1)));
              sent++;
            end
            send_item(OP_FORWARD, rand_q88(), rand_q88(), rand_q88(), i == run_len - 1);
            sent++;
          end
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 6)) begin
            send_item(OP_BACKWARD, rand_q88(), rand_q88(), rand_q88(),
                      1'($urandom_range(0, 1)));
            sent++;
          end
        end else begin
          // A stray forward item joins whichever run comes next.
          send_item(OP_FORWARD, rand_q88(), rand_q88(), rand_q88(), 1'b0);
          sent++;
        end
      end
      sender_bursty = 1'b1;
    end
  endtask

  // Long back-to-back runs: the sum grows far past 32 bits, then a run of small squares.
  task automatic test_long_runs();
    drain_block();
    sender_bursty = 1'b0;
    for (int unsigned i = 0; i < LONG_RUN_ITEMS; i++) begin
      send_item(OP_FORWARD, Q88_MAX, Q88_MIN, '0, i == LONG_RUN_ITEMS - 1);
    end
    for (int unsigned i = 0; i < LONG_RUN_ITEMS; i++) begin
      send_item(OP_FORWARD, Q88_ONE, 16'h0000, '0, i == LONG_RUN_ITEMS - 1);
    end
    sender_bursty = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_element_reg();
    test_register_access();
    test_forward_loss();
    test_output_backpressure();
    test_random_traffic();
    test_long_runs();
    drain_block();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("mse_loss_forward_backward_unit test passed");
    end else begin
      $display("mse_loss_forward_backward_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/mlfb_pkg.sv
design/mlfb_front.sv
design/mlfb_fifo.sv
design/mlfb_div.sv
design/mlfb_back.sv
design/mse_loss_forward_backward_unit.sv
design/mlfb_checker.sv
bench/tb_mse_loss_forward_backward_unit.sv
